FILE: design/wfrp_pkg.sv
// ---------------------------------------------------------------------------
// wfrp_pkg
// Shared types and constants for the WebSocket frame receive parser: parse
// phases, length codes and the command that passes from the parser to the
// output side.
// ---------------------------------------------------------------------------
package wfrp_pkg;

    localparam int LEN_W       = 63;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [5:0] {
        PH_B0    = 6'b000001,
        PH_B1    = 6'b000010,
        PH_EXT16 = 6'b000100,
        PH_EXT64 = 6'b001000,
        PH_KEY   = 6'b010000,
        PH_DATA  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic             kind;
        logic             fin;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
        logic [7:0]       key;
        logic             last;
    } t_cmd;

endpackage

FILE: design/wfrp_front.sv
// ---------------------------------------------------------------------------
// wfrp_front
// Byte parser: walks the frame header one byte per transfer, keeps the length,
// key and payload countdown, and issues a header or payload command.
// ---------------------------------------------------------------------------
module wfrp_front import wfrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase           r_phase,     n_phase;
    logic             r_fin,       n_fin;
    logic [3:0]       r_opcode,    n_opcode;
    logic             r_masked,    n_masked;
    logic [LEN_W-1:0] r_length,    n_length;
    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic [2:0]       r_count,     n_count;
    logic [31:0]      r_key,       n_key;
    logic [1:0]       r_lane,      n_lane;

    logic       len_done;
    logic       hdr_done;
    logic       data_last;
    logic [6:0] len7;

    assign len7 = i_rx_byte[6:0];

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_count     = r_count;
        n_key       = r_key;
        n_lane      = r_lane;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        data_last   = 1'b0;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_B1: begin
                    n_masked = i_rx_byte[7];
                    n_key    = '0;
                    n_count  = '0;
                    if (len7 == LEN7_EXT16) begin
                        n_length = '0;
                        n_phase  = PH_EXT16;
                    end else if (len7 == LEN7_EXT64) begin
                        n_length = '0;
                        n_phase  = PH_EXT64;
                    end else begin
                        n_length = {{(LEN_W-7){1'b0}}, len7};
                        len_done = 1'b1;
                    end
                end
                PH_EXT16: begin
                    n_length = {{(LEN_W-16){1'b0}}, r_length[7:0], i_rx_byte};
                    n_count  = r_count + 3'd1;
                    len_done = (n_count >= EXT16_BYTES);
                end
                PH_EXT64: begin
                    n_length = {r_length[LEN_W-9:0], i_rx_byte};
                    n_count  = r_count + 3'd1;
                    len_done = (n_count == 3'd0);
                end
                PH_KEY: begin
                    n_key    = {r_key[23:0], i_rx_byte};
                    n_count  = r_count + 3'd1;
                    hdr_done = (n_count >= KEY_BYTES);
                end
                PH_DATA: begin
                    n_remaining  = r_remaining - {{(LEN_W-1){1'b0}}, 1'b1};
                    data_last    = (r_remaining == {{(LEN_W-1){1'b0}}, 1'b1});
                    n_lane       = r_lane + 2'd1;
                    o_push       = 1'b1;
                    o_cmd.kind   = KIND_PAYLOAD;
                    o_cmd.fin    = r_fin;
                    o_cmd.opcode = r_opcode;
                    o_cmd.masked = r_masked;
                    o_cmd.length = r_length;
                    o_cmd.data   = i_rx_byte;
                    o_cmd.key    = r_key[{~r_lane, 3'b000} +: 8];
                    o_cmd.last   = data_last;
                    if (data_last) begin
                        n_phase = PH_B0;
                    end
                end
                default: begin
                    n_fin    = i_rx_byte[7];
                    n_opcode = i_rx_byte[3:0];
                    n_phase  = PH_B1;
                end
            endcase

            if (len_done) begin
                n_count = '0;
                if (n_masked) begin
                    n_phase = PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                n_remaining  = n_length;
                n_count      = '0;
                n_lane       = '0;
                o_push       = 1'b1;
                o_cmd.kind   = KIND_HEADER;
                o_cmd.fin    = n_fin;
                o_cmd.opcode = n_opcode;
                o_cmd.masked = n_masked;
                o_cmd.length = n_length;
                o_cmd.data   = '0;
                o_cmd.key    = '0;
                o_cmd.last   = (n_length == '0);
                n_phase      = (n_length == '0) ? PH_B0 : PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_B0;
            r_fin       <= 1'b0;
            r_opcode    <= '0;
            r_masked    <= 1'b0;
            r_length    <= '0;
            r_remaining <= '0;
            r_count     <= '0;
            r_key       <= '0;
            r_lane      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_key       <= n_key;
            r_lane      <= n_lane;
        end
    end

    // payload countdown must never sit at zero while bytes are expected
    a_data_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remaining != '0)
        else $error("payload phase with zero bytes remaining");

    a_key_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY |-> r_masked)
        else $error("key bytes read for an unmasked frame");

endmodule

FILE: design/wfrp_queue.sv
// ---------------------------------------------------------------------------
// wfrp_queue
// Short command queue between the parser and the output register, so that
// either side can stall without stopping the other at once.
// ---------------------------------------------------------------------------
module wfrp_queue import wfrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QUEUE_AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QUEUE_AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + QUEUE_CW'(1);
            2'b01:   n_count = r_count - QUEUE_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command pushed into a full queue");

endmodule

FILE: design/wfrp_back.sv
// ---------------------------------------------------------------------------
// wfrp_back
// Output side: takes commands from the queue, unmasks payload bytes and holds
// each result in the output register until it is transferred.
// ---------------------------------------------------------------------------
module wfrp_back import wfrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_kind,
    output logic             o_final_fragment,
    output logic [3:0]       o_frame_opcode,
    output logic             o_was_masked,
    output logic [LEN_W-1:0] o_frame_length,
    output logic [7:0]       o_payload_data,
    output logic             o_last
);

    logic r_valid, n_valid;
    t_cmd r_out;

    assign o_pop   = i_cmd_valid && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_out.kind;
    assign o_final_fragment = r_out.fin;
    assign o_frame_opcode   = r_out.opcode;
    assign o_was_masked     = r_out.masked;
    assign o_frame_length   = r_out.length;
    assign o_payload_data   = r_out.data ^ r_out.key;
    assign o_last           = r_out.last;

    a_empty_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.kind == KIND_HEADER && r_out.last |-> r_out.length == '0)
        else $error("header closes a frame with a non-empty payload");

    a_unmasked_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.kind == KIND_PAYLOAD && !r_out.masked |-> r_out.key == '0)
        else $error("unmasked frame carries a non-zero key");

endmodule

FILE: design/websocket_frame_receive_parser.sv
// ---------------------------------------------------------------------------
// websocket_frame_receive_parser
// Receive-side WebSocket frame parser: header decode, extended lengths,
// masking key capture and payload unmasking.
// ---------------------------------------------------------------------------
// Takes one byte per clock on the input channel while o_stall is low and
// produces zero or one result per byte: a header result once the header (and
// key, if masked) is complete, then one unmasked payload byte per payload
// byte, with o_last on the final result of the frame. The parser state machine
// handles each accepted byte as it is transferred, so the sustained rate is one
// byte per clock while neither queue nor output stalls; a result passes through
// the command queue into the output register. A two-entry command queue sits
// between parser and output register, and o_stall rises only when it is full.
module websocket_frame_receive_parser import wfrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_rx_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_kind,
    output logic             o_final_fragment,
    output logic [3:0]       o_frame_opcode,
    output logic             o_was_masked,
    output logic [LEN_W-1:0] o_frame_length,
    output logic [7:0]       o_payload_data,
    output logic             o_last
);

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    wfrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    wfrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    wfrp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_valid),
        .i_cmd            (q_cmd),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_final_fragment (o_final_fragment),
        .o_frame_opcode   (o_frame_opcode),
        .o_was_masked     (o_was_masked),
        .o_frame_length   (o_frame_length),
        .o_payload_data   (o_payload_data),
        .o_last           (o_last)
    );

endmodule
